### design/spq_pkg.sv
package spq_pkg;

   // Default sizing, handed down through the top-level parameters
   localparam int CAPACITY_DEFAULT     = 16;
   localparam int PAYLOAD_BITS_DEFAULT = 32;

   // Fixed field widths
   localparam int PRIO_BITS    = 16;
   localparam int CMD_BITS     = 2;
   localparam int STATUS_BITS  = 2;
   localparam int FILL_BITS    = 5;
   localparam int PORT_PL_BITS = 32;

   // Command codes
   typedef enum logic [CMD_BITS-1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   // Result status codes
   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Shift control broadcast to every cell of the chain
   typedef struct packed {
      logic push;
      logic pop;
   } spq_ctrl_type;

endpackage

### design/sorted_insert_priority_queue.sv
// Sorted priority queue built as a chain of compare-and-shift cells.
// Command channel: an operation (push, pop front, clear) is transferred on a
// rising edge where start is high and busy is low. busy stays low: the chain
// takes one command every cycle.
// Each command gives exactly one result, shown on the rsp_ ports for one cycle
// with rsp_strobe high, in the cycle after the command transfer (throughput 1
// command per cycle). Every cell compares its own priority with the pushed one
// in parallel.
// Push places the entry ahead of the first held entry of equal or greater
// priority; a push into a full queue is dropped with status full. Pop returns
// the lowest priority entry, or status empty when nothing is held. fill_count
// is the count after the command, kept to its low 5 bits.
// The receiver cannot stall: results must be taken in the strobe cycle.
// Synchronous reset empties the queue at once and clears the strobe; slot
// contents are not cleared and are never seen until written.
module sorted_insert_priority_queue
   import spq_pkg::*;
#(
   parameter int CAPACITY     = CAPACITY_DEFAULT,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [CMD_BITS-1:0]     req_cmd,
   input  logic [PRIO_BITS-1:0]    req_item_priority,
   input  logic [PORT_PL_BITS-1:0] req_item_payload,
   output logic                    rsp_strobe,
   output logic                    rsp_out_valid,
   output logic [PRIO_BITS-1:0]    rsp_out_priority,
   output logic [PORT_PL_BITS-1:0] rsp_out_payload,
   output logic [STATUS_BITS-1:0]  rsp_status,
   output logic [FILL_BITS-1:0]    rsp_fill_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   logic                    accept;
   spq_ctrl_type            ctrl;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [PAYLOAD_BITS-1:0] new_payload;

   logic                    cell_le      [CAPACITY];
   logic [PRIO_BITS-1:0]    cell_prio    [CAPACITY];
   logic [PAYLOAD_BITS-1:0] cell_payload [CAPACITY];

   logic                    strobe_ff;
   logic                    valid_ff, valid_in;
   logic [PRIO_BITS-1:0]    oprio_ff, oprio_in;
   logic [PORT_PL_BITS-1:0] odata_ff, odata_in;
   logic [STATUS_BITS-1:0]  status_ff, status_in;
   logic [FILL_BITS-1:0]    fill_ff;

   assign busy        = 1'b0;
   assign accept      = start && !busy;
   assign new_payload = PAYLOAD_BITS'(req_item_payload);

   // Command decode: chain control, next count and result fields
   always_comb begin
      ctrl      = '0;
      count_in  = count_ff;
      valid_in  = 1'b0;
      oprio_in  = '0;
      odata_in  = '0;
      status_in = ST_OK;
      if (accept) begin
         case (req_cmd)
            CMD_PUSH: begin
               if (count_ff >= CAP_CNT) begin
                  status_in = ST_FULL;
               end else begin
                  ctrl.push = 1'b1;
                  count_in  = count_ff + 1'b1;
               end
            end
            CMD_POP: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  ctrl.pop = 1'b1;
                  count_in = count_ff - 1'b1;
                  valid_in = 1'b1;
                  oprio_in = cell_prio[0];
                  odata_in = PORT_PL_BITS'(cell_payload[0]);
               end
            end
            CMD_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Row of cells; neighbors exchange entries on each shift
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                    left_le;
      logic [PRIO_BITS-1:0]    left_prio;
      logic [PAYLOAD_BITS-1:0] left_payload;
      logic [PRIO_BITS-1:0]    right_prio;
      logic [PAYLOAD_BITS-1:0] right_payload;

      if (i == 0) begin : g_head
         assign left_le      = 1'b0;
         assign left_prio    = req_item_priority;
         assign left_payload = new_payload;
      end else begin : g_body
         assign left_le      = cell_le[i-1];
         assign left_prio    = cell_prio[i-1];
         assign left_payload = cell_payload[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_prio    = cell_prio[i];
         assign right_payload = cell_payload[i];
      end else begin : g_inner
         assign right_prio    = cell_prio[i+1];
         assign right_payload = cell_payload[i+1];
      end

      spq_cell #(
         .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .occupied      (CNT_W'(i) < count_ff),
         .new_prio      (req_item_priority),
         .new_payload   (new_payload),
         .left_le       (left_le),
         .left_prio     (left_prio),
         .left_payload  (left_payload),
         .right_prio    (right_prio),
         .right_payload (right_payload),
         .le            (cell_le[i]),
         .prio          (cell_prio[i]),
         .payload       (cell_payload[i])
      );
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= accept;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      valid_ff  <= valid_in;
      oprio_ff  <= oprio_in;
      odata_ff  <= odata_in;
      status_ff <= status_in;
      fill_ff   <= FILL_BITS'(count_in);
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_out_valid    = valid_ff;
   assign rsp_out_priority = oprio_ff;
   assign rsp_out_payload  = odata_ff;
   assign rsp_status       = status_ff;
   assign rsp_fill_count   = fill_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count above capacity");

   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("command transfer without result strobe");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("result strobe without command transfer");

   a_pop_gives: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_POP && count_ff != '0) |=> (rsp_out_valid && rsp_status == ST_OK))
      else $error("pop on non-empty queue gave no entry");

   a_front_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(2)) |-> (cell_prio[0] <= cell_prio[1]))
      else $error("front entries out of order");
`endif

endmodule

### design/spq_cell.sv
module spq_cell
   import spq_pkg::*;
#(
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEFAULT
) (
   input  logic                    clock,
   input  spq_ctrl_type            ctrl,
   input  logic                    occupied,
   input  logic [PRIO_BITS-1:0]    new_prio,
   input  logic [PAYLOAD_BITS-1:0] new_payload,
   input  logic                    left_le,
   input  logic [PRIO_BITS-1:0]    left_prio,
   input  logic [PAYLOAD_BITS-1:0] left_payload,
   input  logic [PRIO_BITS-1:0]    right_prio,
   input  logic [PAYLOAD_BITS-1:0] right_payload,
   output logic                    le,
   output logic [PRIO_BITS-1:0]    prio,
   output logic [PAYLOAD_BITS-1:0] payload
);

   logic [PRIO_BITS-1:0]    prio_ff, prio_in;
   logic [PAYLOAD_BITS-1:0] payload_ff, payload_in;

   // New entry belongs at or ahead of this slot (empty slots always qualify)
   assign le = !occupied || (prio_ff >= new_prio);

   // Push: slots at or past the insert point shift right; the first takes the new entry.
   // Pop: every slot takes its right neighbor.
   always_comb begin
      prio_in    = prio_ff;
      payload_in = payload_ff;
      if (ctrl.push && le) begin
         if (left_le) begin
            prio_in    = left_prio;
            payload_in = left_payload;
         end else begin
            prio_in    = new_prio;
            payload_in = new_payload;
         end
      end else if (ctrl.pop) begin
         prio_in    = right_prio;
         payload_in = right_payload;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff    <= prio_in;
      payload_ff <= payload_in;
   end

   assign prio    = prio_ff;
   assign payload = payload_ff;

endmodule

### sim/spq_pop_checker.sv
`timescale 1ns / 1ps

module spq_pop_checker
   import spq_pkg::*;
#(
   parameter int CAPACITY     = CAPACITY_DEFAULT,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  logic [CMD_BITS-1:0]     req_cmd,
   input  logic [PRIO_BITS-1:0]    req_item_priority,
   input  logic [PORT_PL_BITS-1:0] req_item_payload,
   input  logic                    rsp_strobe,
   input  logic                    rsp_out_valid,
   input  logic [PRIO_BITS-1:0]    rsp_out_priority,
   input  logic [PORT_PL_BITS-1:0] rsp_out_payload,
   input  logic [STATUS_BITS-1:0]  rsp_status,
   input  logic [FILL_BITS-1:0]    rsp_fill_count,
   output int                      fail_count,
   output int                      pending_count
);

   // One result of a queue operation, as the block should show it
   typedef struct packed {
      logic                    valid;
      logic [PRIO_BITS-1:0]    prio;
      logic [PORT_PL_BITS-1:0] payload;
      logic [STATUS_BITS-1:0]  status;
      logic [FILL_BITS-1:0]    fill;
   } op_result_type;

   // Mirror of the queue contents, sorted by ascending priority
   logic [PRIO_BITS-1:0]    held_prio [CAPACITY];
   logic [PORT_PL_BITS-1:0] held_payload [CAPACITY];
   int                      held_count;

   op_result_type awaited_results [$];

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      fail_count++;
   endtask

   // Apply one command to the mirror and return the result it should give
   function automatic op_result_type apply_queue_op(input logic [CMD_BITS-1:0] cmd,
                                                    input logic [PRIO_BITS-1:0] prio,
                                                    input logic [PORT_PL_BITS-1:0] data);
      op_result_type           res;
      int                      pos;
      logic [PORT_PL_BITS-1:0] kept;
      res  = '0;
      kept = (PAYLOAD_BITS >= PORT_PL_BITS) ? data
                                            : data & ((32'd1 << PAYLOAD_BITS) - 32'd1);
      case (cmd)
         CMD_PUSH: begin
            if (held_count >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               // new entry goes ahead of the first equal or greater priority
               pos = 0;
               while (pos < held_count && held_prio[pos] < prio) pos++;
               for (int k = held_count; k > pos; k--) begin
                  held_prio[k]    = held_prio[k-1];
                  held_payload[k] = held_payload[k-1];
               end
               held_prio[pos]    = prio;
               held_payload[pos] = kept;
               held_count++;
            end
         end
         CMD_POP: begin
            if (held_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.valid   = 1'b1;
               res.prio    = held_prio[0];
               res.payload = held_payload[0];
               for (int k = 1; k < held_count; k++) begin
                  held_prio[k-1]    = held_prio[k];
                  held_payload[k-1] = held_payload[k];
               end
               held_count--;
            end
         end
         CMD_CLEAR: held_count = 0;
         default: ;
      endcase
      res.fill = held_count[FILL_BITS-1:0];
      return res;
   endfunction

   // Check results first, then predict for the command transferred this edge
   always @(posedge clock) begin
      op_result_type want;
      if (reset) begin
         held_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("unexpected result", 64'({rsp_out_valid, rsp_status}),
                               64'd0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_out_valid !== want.valid)
                  report_mismatch("out_valid", 64'(rsp_out_valid), 64'(want.valid));
               if (rsp_out_priority !== want.prio)
                  report_mismatch("out_priority", 64'(rsp_out_priority), 64'(want.prio));
               if (rsp_out_payload !== want.payload)
                  report_mismatch("out_payload", 64'(rsp_out_payload), 64'(want.payload));
               if (rsp_status !== want.status)
                  report_mismatch("status", 64'(rsp_status), 64'(want.status));
               if (rsp_fill_count !== want.fill)
                  report_mismatch("fill_count", 64'(rsp_fill_count), 64'(want.fill));
            end
         end
         if (start && !busy)
            awaited_results.insert(awaited_results.size(),
                                   apply_queue_op(req_cmd, req_item_priority,
                                                  req_item_payload));
      end
      pending_count = awaited_results.size();
   end

endmodule

### sim/tb_sorted_insert_priority_queue.sv
`timescale 1ns / 1ps

module tb_sorted_insert_priority_queue;
   import spq_pkg::*;

   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1750;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [CMD_BITS-1:0]     req_cmd;
   logic [PRIO_BITS-1:0]    req_item_priority;
   logic [PORT_PL_BITS-1:0] req_item_payload;
   logic                    rsp_strobe;
   logic                    rsp_out_valid;
   logic [PRIO_BITS-1:0]    rsp_out_priority;
   logic [PORT_PL_BITS-1:0] rsp_out_payload;
   logic [STATUS_BITS-1:0]  rsp_status;
   logic [FILL_BITS-1:0]    rsp_fill_count;
   int                      fail_count;
   int                      pending_count;
   int                      idle_pct;

   sorted_insert_priority_queue uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_item_priority (req_item_priority),
      .req_item_payload  (req_item_payload),
      .rsp_strobe        (rsp_strobe),
      .rsp_out_valid     (rsp_out_valid),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_out_payload   (rsp_out_payload),
      .rsp_status        (rsp_status),
      .rsp_fill_count    (rsp_fill_count)
   );

   spq_pop_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_item_priority (req_item_priority),
      .req_item_payload  (req_item_payload),
      .rsp_strobe        (rsp_strobe),
      .rsp_out_valid     (rsp_out_valid),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_out_payload   (rsp_out_payload),
      .rsp_status        (rsp_status),
      .rsp_fill_count    (rsp_fill_count),
      .fail_count        (fail_count),
      .pending_count     (pending_count)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Drive one command, with random idle cycles ahead of it, until transferred
   task automatic send_cmd(input logic [CMD_BITS-1:0] cmd, input logic [PRIO_BITS-1:0] prio,
                           input logic [PORT_PL_BITS-1:0] data);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start             <= 1'b1;
      req_cmd           <= cmd;
      req_item_priority <= prio;
      req_item_payload  <= data;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Priorities clustered so that ties and both ends come up often
   function automatic logic [PRIO_BITS-1:0] pick_priority();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2, 3, 4: return PRIO_BITS'($urandom_range(7));
         5: return PRIO_BITS'(16'h8000 + $urandom_range(3));
         default: return PRIO_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [PORT_PL_BITS-1:0] pick_payload();
      case ($urandom_range(15))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int push_pct;
      int seg_left;
      int roll;
      reset             = 1'b1;
      start             = 1'b0;
      req_cmd           = CMD_PUSH;
      req_item_priority = '0;
      req_item_payload  = '0;
      idle_pct          = 0;
      push_pct          = 50;
      seg_left          = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty pop, unused code, fill to full with extremes and ties,
      // push and unused code on a full queue, pops, clear, then empty pop
      send_cmd(CMD_POP, '1, '1);
      send_cmd(CMD_UNUSED, 16'h1234, 32'h5678_9abc);
      send_cmd(CMD_PUSH, '1, '1);
      send_cmd(CMD_PUSH, '0, '0);
      send_cmd(CMD_PUSH, 16'h8000, 32'h0000_0001);
      send_cmd(CMD_PUSH, 16'h8000, 32'h0000_0002);
      send_cmd(CMD_PUSH, 16'h8000, 32'h0000_0003);
      for (int k = 0; k < CAPACITY_DEFAULT - 5; k++)
         send_cmd(CMD_PUSH, PRIO_BITS'(16'h9000 + k), $urandom);
      send_cmd(CMD_PUSH, '0, 32'hdead_beef);
      send_cmd(CMD_UNUSED, '0, '0);
      repeat (3) send_cmd(CMD_POP, '0, '0);
      send_cmd(CMD_CLEAR, '1, '1);
      send_cmd(CMD_POP, '0, '0);

      // Random: three idle phases, push/pop bias changing in segments
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 36 : (phase == 1) ? 71 : 0;
         for (int n = 0; n < RANDOM_ITEMS / 3 + 1; n++) begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(80, 20);
               case ($urandom_range(2))
                  0: push_pct = 75;
                  1: push_pct = 50;
                  default: push_pct = 25;
               endcase
            end
            seg_left--;
            roll = $urandom_range(99);
            if (roll < 2)
               send_cmd(CMD_CLEAR, pick_priority(), pick_payload());
            else if (roll < 4)
               send_cmd(CMD_UNUSED, pick_priority(), pick_payload());
            else if (roll < 4 + push_pct * 96 / 100)
               send_cmd(CMD_PUSH, pick_priority(), pick_payload());
            else
               send_cmd(CMD_POP, pick_priority(), pick_payload());
         end
      end
      start <= 1'b0;

      // Drain: wait for every expected result, then a few more cycles
      for (int w = 0; w < 1000 && pending_count != 0; w++) @(negedge clock);
      repeat (4) @(negedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
